FILE: rtl/sfd_pkg.sv
package sfd_pkg;

    localparam int SFD_MAX_FRAME_BYTES = 128;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DELIM     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESC       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_DELIM = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_ESC   = 2'd3;

    localparam logic [7:0] RST_DELIM     = 8'd192;
    localparam logic [7:0] RST_ESC       = 8'd219;
    localparam logic [7:0] RST_ESC_DELIM = 8'd220;
    localparam logic [7:0] RST_ESC_ESC   = 8'd221;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_SUM    = 3'd1;
    localparam logic [2:0] ST_EMPTY      = 3'd2;
    localparam logic [2:0] ST_SHORT      = 3'd3;
    localparam logic [2:0] ST_OVERFLOW   = 3'd4;
    localparam logic [2:0] ST_BAD_ESCAPE = 3'd5;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic [7:0] sender_id;
        logic [7:0] receiver_id;
        logic [6:0] payload_length;
    } t_result;

endpackage

FILE: rtl/sfd_core.sv
module sfd_core import sfd_pkg::*; #(
    parameter int MAX_FRAME_BYTES = SFD_MAX_FRAME_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_step,
    input  logic [7:0]           i_byte,
    output logic                 o_res_valid,
    output t_result              o_res
);

    localparam int         EmitRaw  = MAX_FRAME_BYTES - 3;
    localparam logic [6:0] EMIT_LEN = (EmitRaw > 127) ? 7'd127 : 7'(EmitRaw);
    localparam logic [7:0] MAX_CNT  = 8'(MAX_FRAME_BYTES);

    typedef enum logic [2:0] {
        S_WAIT = 3'b001,
        S_MSG  = 3'b010,
        S_ESC  = 3'b100
    } t_mode;

    logic [7:0] r_delim, r_esc, r_esc_delim, r_esc_esc;

    t_mode      r_mode, n_mode;
    logic [7:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_last_wt, n_last_wt;
    logic [7:0] r_dl0, r_dl1, r_dl2;
    logic [7:0] n_dl0, n_dl1, n_dl2;

    logic       w_store;
    logic       w_close;
    logic [7:0] w_val;
    logic [7:0] w_wt;
    logic [7:0] w_expect;
    logic [7:0] w_len_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim     <= RST_DELIM;
            r_esc       <= RST_ESC;
            r_esc_delim <= RST_ESC_DELIM;
            r_esc_esc   <= RST_ESC_ESC;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_DELIM:     r_delim     <= i_cfg_wdata;
                REG_ESC:       r_esc       <= i_cfg_wdata;
                REG_ESC_DELIM: r_esc_delim <= i_cfg_wdata;
                REG_ESC_ESC:   r_esc_esc   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // classify the byte against the current mode
    always_comb begin
        w_store = 1'b0;
        w_close = 1'b0;
        w_val   = i_byte;
        w_wt    = i_byte;
        case (r_mode)
            S_MSG: begin
                if (i_byte != r_esc && i_byte == r_delim) begin
                    w_close = 1'b1;
                end else if (i_byte != r_esc) begin
                    w_store = 1'b1;
                end
            end
            S_ESC: begin
                if (i_byte == r_esc_delim) begin
                    w_store = 1'b1;
                    w_val   = r_delim;
                    w_wt    = r_esc + r_esc_delim;
                end else if (i_byte == r_esc_esc) begin
                    w_store = 1'b1;
                    w_val   = r_esc;
                    w_wt    = r_esc + r_esc_esc;
                end
            end
            default: ;
        endcase
    end

    assign w_expect  = r_sum - r_last_wt;
    assign w_len_raw = r_count - 8'd3;

    always_comb begin
        n_mode      = r_mode;
        n_count     = r_count;
        n_sum       = r_sum;
        n_last_wt   = r_last_wt;
        n_dl0       = r_dl0;
        n_dl1       = r_dl1;
        n_dl2       = r_dl2;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_step) begin
            if (w_store) begin
                if (r_count >= MAX_CNT) begin
                    n_mode               = S_WAIT;
                    n_count              = '0;
                    n_sum                = '0;
                    n_last_wt            = '0;
                    o_res_valid          = 1'b1;
                    o_res.kind           = KIND_VERDICT;
                    o_res.status         = ST_OVERFLOW;
                    o_res.payload_length = EMIT_LEN;
                end else begin
                    if (r_count >= 8'd3) begin
                        o_res_valid     = 1'b1;
                        o_res.kind      = KIND_PAYLOAD;
                        o_res.data_byte = r_dl0;
                    end
                    n_dl0     = r_dl1;
                    n_dl1     = r_dl2;
                    n_dl2     = w_val;
                    n_count   = r_count + 8'd1;
                    n_sum     = r_sum + w_wt;
                    n_last_wt = w_wt;
                    n_mode    = S_MSG;
                end
            end else if (w_close) begin
                o_res_valid = 1'b1;
                o_res.kind  = KIND_VERDICT;
                if (r_count == 8'd0) begin
                    o_res.status = ST_EMPTY;
                end else if (r_count < 8'd3) begin
                    o_res.status = ST_SHORT;
                end else begin
                    o_res.status         = (w_expect == r_dl2) ? ST_OK : ST_BAD_SUM;
                    o_res.sender_id      = r_dl0;
                    o_res.receiver_id    = r_dl1;
                    o_res.payload_length = (w_len_raw > 8'd127) ? 7'd127 : w_len_raw[6:0];
                end
                n_mode    = S_MSG;
                n_count   = '0;
                n_sum     = '0;
                n_last_wt = '0;
            end else begin
                case (r_mode)
                    S_MSG: n_mode = S_ESC;
                    S_ESC: begin
                        n_mode       = S_WAIT;
                        n_count      = '0;
                        n_sum        = '0;
                        n_last_wt    = '0;
                        o_res_valid  = 1'b1;
                        o_res.kind   = KIND_VERDICT;
                        o_res.status = ST_BAD_ESCAPE;
                    end
                    default: begin
                        if (i_byte == r_delim) begin
                            n_mode    = S_MSG;
                            n_count   = '0;
                            n_sum     = '0;
                            n_last_wt = '0;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= S_WAIT;
            r_count   <= '0;
            r_sum     <= '0;
            r_last_wt <= '0;
        end else begin
            r_mode    <= n_mode;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_last_wt <= n_last_wt;
        end
    end

    // delay line is only read once three bytes of the frame are in it
    always_ff @(posedge i_clk) begin
        r_dl0 <= n_dl0;
        r_dl1 <= n_dl1;
        r_dl2 <= n_dl2;
    end

endmodule

FILE: rtl/sfd_outbuf.sv
module sfd_outbuf import sfd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    output t_result o_data,
    input  logic    i_ready
);

    // two-entry queue, so a result can wait while the next beat is produced
    t_result    r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    logic w_push;
    logic w_pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: rtl/slip_frame_decoder_checksum_unit.sv
// a byte is held in the input register and its result in the output queue before it reaches the master side
// throughput: one byte per cycle unless the output queue is full, set by sfd_core
// bytes that cause no result still take one pass through the input register
// reset (synchronous, active low) clears frame state, queues and handshakes,
// and loads the default delimiter and escape codes
module slip_frame_decoder_checksum_unit import sfd_pkg::*; #(
    parameter int MAX_FRAME_BYTES = SFD_MAX_FRAME_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // rx_byte
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // data_byte[7:0], status[10:8], sender_id[18:11], receiver_id[26:19],
    // payload_length[33:27], zero fill[39:34]
    output logic [39:0]          m_axis_tdata,
    output logic                 m_axis_tuser    // kind
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;

    logic    w_step;
    logic    w_buf_ready;
    logic    w_res_valid;
    t_result w_res;
    t_result w_out;

    assign w_step        = r_in_valid && w_buf_ready;
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    sfd_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    sfd_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_step && w_res_valid),
        .i_data  (w_res),
        .o_ready (w_buf_ready),
        .o_valid (m_axis_tvalid),
        .o_data  (w_out),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tuser = w_out.kind;
    assign m_axis_tdata = {6'd0, w_out.payload_length, w_out.receiver_id,
                           w_out.sender_id, w_out.status, w_out.data_byte};

endmodule

FILE: tb/frame_decode_checker.sv
`timescale 1ns / 100ps

module frame_decode_checker import sfd_pkg::*; #(
    parameter int MAX_FRAME_BYTES = SFD_MAX_FRAME_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [7:0]           i_s_tdata,   // rx_byte
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    // data_byte[7:0], status[10:8], sender_id[18:11], receiver_id[26:19],
    // payload_length[33:27], zero fill[39:34]
    input  logic [39:0]          i_m_tdata,
    input  logic                 i_m_tuser,   // kind
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_payload_beats,
    output int                   o_verdicts,
    output logic [7:0]           o_status_seen
);

    typedef enum logic [2:0] {
        HUNT     = 3'b001,
        IN_FRAME = 3'b010,
        ESC_SEEN = 3'b100
    } t_rx_mode;

    // codes as the block should currently hold them
    logic [7:0] code_delim;
    logic [7:0] code_esc;
    logic [7:0] code_esc_delim;
    logic [7:0] code_esc_esc;

    t_rx_mode   rx_mode;
    logic [7:0] frame_bytes;
    logic [7:0] frame_sum;
    logic [7:0] newest_weight;
    logic [7:0] tail [3];

    t_result    pending_results [$];
    int         fails = 0;
    int         payload_beats = 0;
    int         verdicts = 0;
    logic [7:0] status_seen = '0;

    function automatic t_result make_verdict(input logic [2:0] st, input logic [7:0] snd,
                                             input logic [7:0] rcv, input int len);
        t_result r;
        r.kind           = KIND_VERDICT;
        r.data_byte      = 8'h00;
        r.status         = st;
        r.sender_id      = snd;
        r.receiver_id    = rcv;
        r.payload_length = (len > 127) ? 7'd127 : 7'(len);
        return r;
    endfunction

    task automatic clear_frame();
        frame_bytes   = 8'h00;
        frame_sum     = 8'h00;
        newest_weight = 8'h00;
        tail[0]       = 8'h00;
        tail[1]       = 8'h00;
        tail[2]       = 8'h00;
    endtask

    task automatic store_decoded(input logic [7:0] value, input logic [7:0] weight);
        t_result r;
        if (frame_bytes >= MAX_FRAME_BYTES) begin
            clear_frame();
            rx_mode = HUNT;
            pending_results.push_back(make_verdict(ST_OVERFLOW, 8'h00, 8'h00,
                                                   MAX_FRAME_BYTES - 3));
        end else begin
            // the oldest of the three held bytes is now known to be payload
            if (frame_bytes >= 3) begin
                r = '0;
                r.kind      = KIND_PAYLOAD;
                r.data_byte = tail[0];
                pending_results.push_back(r);
            end
            tail[0]       = tail[1];
            tail[1]       = tail[2];
            tail[2]       = value;
            frame_bytes   = frame_bytes + 8'd1;
            frame_sum     = frame_sum + weight;
            newest_weight = weight;
            rx_mode       = IN_FRAME;
        end
    endtask

    task automatic decode_line_byte(input logic [7:0] c);
        logic [7:0] sum_before;
        case (rx_mode)
            IN_FRAME: begin
                // escape wins over delimiter when the codes overlap
                if (c == code_esc) begin
                    rx_mode = ESC_SEEN;
                end else if (c == code_delim) begin
                    if (frame_bytes == 0) begin
                        pending_results.push_back(make_verdict(ST_EMPTY, 8'h00, 8'h00, 0));
                    end else if (frame_bytes < 3) begin
                        pending_results.push_back(make_verdict(ST_SHORT, 8'h00, 8'h00, 0));
                    end else begin
                        sum_before = frame_sum - newest_weight;
                        pending_results.push_back(make_verdict(
                            (sum_before == tail[2]) ? ST_OK : ST_BAD_SUM,
                            tail[0], tail[1], frame_bytes - 3));
                    end
                    clear_frame();
                    rx_mode = IN_FRAME;
                end else begin
                    store_decoded(c, c);
                end
            end
            ESC_SEEN: begin
                if (c == code_esc_delim) begin
                    store_decoded(code_delim, code_esc + code_esc_delim);
                end else if (c == code_esc_esc) begin
                    store_decoded(code_esc, code_esc + code_esc_esc);
                end else begin
                    clear_frame();
                    rx_mode = HUNT;
                    pending_results.push_back(make_verdict(ST_BAD_ESCAPE, 8'h00, 8'h00, 0));
                end
            end
            default: begin
                if (c == code_delim) begin
                    clear_frame();
                    rx_mode = IN_FRAME;
                end else begin
                    rx_mode = HUNT;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            fails++;
            if (fails <= 50)
                $display("%t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            code_delim     = RST_DELIM;
            code_esc       = RST_ESC;
            code_esc_delim = RST_ESC_DELIM;
            code_esc_esc   = RST_ESC_ESC;
            rx_mode        = HUNT;
            clear_frame();
            pending_results.delete();
        end else begin
            // results first: a result never belongs to a byte taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                got.kind           = i_m_tuser;
                got.data_byte      = i_m_tdata[7:0];
                got.status         = i_m_tdata[10:8];
                got.sender_id      = i_m_tdata[18:11];
                got.receiver_id    = i_m_tdata[26:19];
                got.payload_length = i_m_tdata[33:27];
                if (got.kind === KIND_VERDICT) begin
                    verdicts++;
                    status_seen[got.status] = 1'b1;
                end else begin
                    payload_beats++;
                end
                if (pending_results.size() == 0) begin
                    fails++;
                    if (fails <= 50)
                        $display("%t: unexpected beat, expected none, actual kind %b data %h",
                                 $time, i_m_tuser, i_m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 8'(want.kind), 8'(got.kind));
                    check_field("data_byte", want.data_byte, got.data_byte);
                    check_field("status", 8'(want.status), 8'(got.status));
                    check_field("sender_id", want.sender_id, got.sender_id);
                    check_field("receiver_id", want.receiver_id, got.receiver_id);
                    check_field("payload_length", 8'(want.payload_length),
                                8'(got.payload_length));
                    check_field("zero fill", 8'h00, 8'(i_m_tdata[39:34]));
                end
            end
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    REG_DELIM:     code_delim     = i_cfg_wdata;
                    REG_ESC:       code_esc       = i_cfg_wdata;
                    REG_ESC_DELIM: code_esc_delim = i_cfg_wdata;
                    REG_ESC_ESC:   code_esc_esc   = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                decode_line_byte(i_s_tdata);
        end
        o_pending       <= pending_results.size();
        o_fail_count    <= fails;
        o_payload_beats <= payload_beats;
        o_verdicts      <= verdicts;
        o_status_seen   <= status_seen;
    end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import sfd_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [7:0]           cfg_wdata = 8'h00;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = 8'h00;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [39:0]          m_tdata;
    logic                 m_tuser;

    int         fail_count;
    int         pending;
    int         payload_beats;
    int         verdicts;
    logic [7:0] status_seen;

    // codes as last written, used to build line traffic
    logic [7:0] tx_delim     = RST_DELIM;
    logic [7:0] tx_esc       = RST_ESC;
    logic [7:0] tx_esc_delim = RST_ESC_DELIM;
    logic [7:0] tx_esc_esc   = RST_ESC_ESC;

    int tx_count = 0;
    int settings_used = 1;
    bit tx_burst = 1'b0;
    bit hold_req = 1'b0;
    bit hold_done = 1'b0;

    always #6 i_clk = ~i_clk;

    slip_frame_decoder_checksum_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    frame_decode_checker u_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_tvalid      (s_tvalid),
        .i_s_tready      (s_tready),
        .i_s_tdata       (s_tdata),
        .i_m_tvalid      (m_tvalid),
        .i_m_tready      (m_tready),
        .i_m_tdata       (m_tdata),
        .i_m_tuser       (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_payload_beats (payload_beats),
        .o_verdicts      (verdicts),
        .o_status_seen   (status_seen)
    );

    initial begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    // result side: random stalls, bursts with none, and one long hold-off
    initial begin : sink
        int hold;
        int run;
        run = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req && !hold_done) begin
                hold = 100;
                hold_done = 1'b1;
            end else if (run > 0) begin
                hold = 0;
                run--;
            end else begin
                hold = $urandom_range(0, 4);
                if ($urandom_range(0, 9) == 0)
                    run = 20;
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        tx_count++;
    endtask

    // send one decoded byte, escaping it if needed, and add its weight
    task automatic put_byte(input logic [7:0] v, inout logic [7:0] sum);
        if (v == tx_delim) begin
            send_byte(tx_esc);
            send_byte(tx_esc_delim);
            sum = sum + tx_esc + tx_esc_delim;
        end else if (v == tx_esc) begin
            send_byte(tx_esc);
            send_byte(tx_esc_esc);
            sum = sum + tx_esc + tx_esc_esc;
        end else begin
            send_byte(v);
            sum = sum + v;
        end
    endtask

    task automatic send_frame(input logic [7:0] snd, input logic [7:0] rcv, input int npay,
                              input bit bad_sum, input bit close);
        logic [7:0] sum;
        logic [7:0] v;
        int i;
        sum = 8'h00;
        for (i = 0; i < npay; i++) begin
            case ($urandom_range(0, 9))
                0: v = tx_delim;
                1: v = tx_esc;
                2: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                default: v = 8'($urandom_range(0, 255));
            endcase
            put_byte(v, sum);
        end
        put_byte(snd, sum);
        put_byte(rcv, sum);
        v = bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        put_byte(v, sum);
        if (close)
            send_byte(tx_delim);
    endtask

    task automatic wait_drained(input int cap);
        int n;
        n = 0;
        s_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
            n++;
        end while (pending != 0 && n < cap);
        // bytes without a result may still sit in the input register
        repeat (6) @(posedge i_clk);
    endtask

    task automatic set_codes(input logic [7:0] d, input logic [7:0] e,
                             input logic [7:0] ed, input logic [7:0] ee);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= REG_DELIM;
        cfg_wdata <= d;
        @(posedge i_clk);
        cfg_idx   <= REG_ESC;
        cfg_wdata <= e;
        @(posedge i_clk);
        cfg_idx   <= REG_ESC_DELIM;
        cfg_wdata <= ed;
        @(posedge i_clk);
        cfg_idx   <= REG_ESC_ESC;
        cfg_wdata <= ee;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        tx_delim     = d;
        tx_esc       = e;
        tx_esc_delim = ed;
        tx_esc_esc   = ee;
        settings_used++;
    endtask

    task automatic run_mix(input int n);
        int stop;
        int r;
        int k;
        int npay;
        logic [7:0] scratch;
        stop = tx_count + n;
        while (tx_count < stop) begin
            tx_burst = ($urandom_range(0, 5) == 0);
            r = $urandom_range(0, 99);
            if (r < 60) begin
                if ($urandom_range(0, 2) == 0)
                    send_byte(tx_delim);
                npay = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 30)
                                                    : $urandom_range(0, 8);
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), npay,
                           $urandom_range(0, 7) == 0, 1'b1);
            end else if (r < 70) begin
                k = $urandom_range(1, 5);
                repeat (k) send_byte(8'($urandom_range(0, 255)));
            end else if (r < 78) begin
                send_byte(tx_esc);
                send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1))
                    send_byte(tx_delim);
            end else if (r < 86) begin
                k = $urandom_range(1, 2);
                scratch = 8'h00;
                repeat (k) put_byte(8'($urandom_range(0, 255)), scratch);
                send_byte(tx_delim);
            end else if (r < 92) begin
                send_byte(tx_delim);
            end else begin
                // frame cut off before its closing delimiter
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           $urandom_range(0, 6), 1'b0, 1'b0);
            end
        end
        tx_burst = 1'b0;
    endtask

    initial begin : stimulus
        logic [7:0] sum;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: open, empty, short frames, escapes of both codes, bad escapes
        send_byte(8'h41);
        send_byte(tx_delim);
        send_byte(tx_delim);
        send_byte(8'h41);
        send_byte(tx_delim);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(tx_delim);
        sum = 8'h00;
        put_byte(8'h00, sum);
        put_byte(8'hFF, sum);
        put_byte(tx_delim, sum);
        put_byte(tx_esc, sum);
        put_byte(8'h12, sum);
        put_byte(8'h34, sum);
        put_byte(sum, sum);
        send_byte(tx_delim);
        send_frame(8'hFF, 8'h00, 0, 1'b1, 1'b1);
        send_byte(tx_esc);
        send_byte(8'h55);
        send_byte(8'h77);
        send_byte(tx_delim);
        // delimiter right after an escape is a bad escape too
        send_byte(tx_esc);
        send_byte(tx_delim);
        wait_drained(1_000_000);

        run_mix(40);
        // receiver holds off while a long frame streams in
        hold_req = 1'b1;
        tx_burst = 1'b1;
        send_byte(tx_delim);
        send_frame(8'hA5, 8'h5A, 40, 1'b0, 1'b1);
        tx_burst = 1'b0;
        hold_req = 1'b0;
        wait_drained(1_000_000);
        // largest frame that still fits
        send_frame(8'h01, 8'h02, SFD_MAX_FRAME_BYTES - 3, 1'b0, 1'b1);
        run_mix(15);
        wait_drained(1_000_000);

        set_codes(8'h00, 8'hFF, 8'h01, 8'hFE);
        send_byte(tx_delim);
        run_mix(20);
        wait_drained(1_000_000);

        // escaped delimiter code equal to the delimiter, escaped escape equal to escape
        set_codes(8'hFF, 8'h00, 8'hFF, 8'h00);
        send_byte(tx_delim);
        run_mix(15);
        wait_drained(1_000_000);

        // escape and delimiter share a code, both escaped codes the same
        set_codes(8'h7E, 8'h7E, 8'h5E, 8'h5E);
        send_byte(tx_delim);
        run_mix(15);
        wait_drained(1_000_000);

        repeat (2) begin
            set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            send_byte(tx_delim);
            run_mix(15);
            wait_drained(1_000_000);
        end

        set_codes(RST_DELIM, RST_ESC, RST_ESC_DELIM, RST_ESC_ESC);
        send_byte(tx_delim);
        run_mix(15);
        // one decoded byte too many overflows at the checksum
        send_byte(tx_delim);
        send_frame(8'h10, 8'h20, SFD_MAX_FRAME_BYTES - 2, 1'b0, 1'b1);
        run_mix(10);

        wait_drained(20_000);
        $display("run: %0d line bytes over %0d code settings, %0d payload beats and %0d verdicts",
                 tx_count, settings_used, payload_beats, verdicts);
        $display("statuses seen (bit n = status n): %b, results never delivered: %0d",
                 status_seen[5:0], pending);
        if (fail_count == 0 && pending == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
